// File: hdl/flpw_pkg.sv
// Shared types and constants of the four-level page walker.
// Used by flpw_ctrl, flpw_dp and four_level_page_walker; no dependencies.
`default_nettype none

package flpw_pkg;

    localparam int ENTRY_SLOTS = 512;
    localparam int SLOT_W      = 9;
    localparam int VIRT_BITS   = 48;
    localparam int PAGE_SHIFT  = 12;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_XLATE = 1'b1;

    localparam logic [1:0] LAST_LEVEL = 2'd3;

    localparam logic [2:0] FLT_OK       = 3'd0;
    localparam logic [2:0] FLT_NONCANON = 3'd1;
    localparam logic [2:0] FLT_ABSENT   = 3'd2;
    localparam logic [2:0] FLT_USER     = 3'd3;
    localparam logic [2:0] FLT_WRITE    = 3'd4;
    localparam logic [2:0] FLT_LARGE    = 3'd5;
    localparam logic [2:0] FLT_OUTSIDE  = 3'd6;

    // entry bit positions
    localparam int PTE_PRESENT  = 0;
    localparam int PTE_WRITABLE = 1;
    localparam int PTE_USER     = 2;
    localparam int PTE_LARGE    = 7;

    typedef struct packed {
        logic        opcode;
        logic [12:0] entry_index;
        logic [63:0] entry_value;
        logic [63:0] virt_address;
        logic        need_user;
        logic        need_write;
    } t_flpw_in;

    typedef struct packed {
        logic [51:0] phys_address;
        logic        translated;
        logic [2:0]  fault_code;
        logic        kernel_page;
    } t_flpw_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic clr;      // one store word cleared
        logic load;     // transaction accepted
        logic walk;     // evaluate the entry just read
        logic finish;   // result register loads
    } t_flpw_cmd;

    typedef struct packed {
        logic clr_last;  // clearing pass at its last word
        logic load_end;  // accepted item completes without a walk
        logic walk_end;  // walk stops at this level
    } t_flpw_sts;

endpackage

`default_nettype wire

// File: hdl/flpw_ctrl.sv
// Controller of the page walker: clearing pass, accept and walk sequencing.
// Depends on flpw_pkg.
`default_nettype none

module flpw_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  flpw_pkg::t_flpw_sts  i_sts,
    output flpw_pkg::t_flpw_cmd  o_cmd,
    output logic                 o_busy
);

    flpw_pkg::t_state r_state;
    flpw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flpw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            flpw_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = flpw_pkg::ST_IDLE;
                end
            end
            flpw_pkg::ST_IDLE: begin
                if (i_start && !i_sts.load_end) begin
                    n_state = flpw_pkg::ST_WALK;
                end
            end
            flpw_pkg::ST_WALK: begin
                if (i_sts.walk_end) begin
                    n_state = flpw_pkg::ST_IDLE;
                end
            end
            default: n_state = flpw_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            flpw_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            flpw_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.load   = i_start;
                o_cmd.finish = i_start && i_sts.load_end;
            end
            flpw_pkg::ST_WALK: begin
                o_cmd.walk   = 1'b1;
                o_cmd.finish = i_sts.walk_end;
            end
            default: o_cmd = '0;
        endcase
    end

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == flpw_pkg::ST_IDLE)
        else $error("no return to idle after a result");

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flpw_pkg::ST_CLEAR) && i_sts.clr_last |=> r_state == flpw_pkg::ST_IDLE)
        else $error("clearing pass did not end");

    a_load_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state != flpw_pkg::ST_CLEAR)
        else $error("clearing pass re-entered after a transaction");

endmodule

`default_nettype wire

// File: hdl/flpw_dp.sv
// Datapath of the page walker: table store, root register, walk checks, result.
// Depends on flpw_pkg; sequenced by flpw_ctrl.
`default_nettype none

module flpw_dp #(
    parameter int TABLE_FRAMES = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [3:0]           i_cfg_data,
    input  flpw_pkg::t_flpw_in   i_item,
    input  flpw_pkg::t_flpw_cmd  i_cmd,
    output flpw_pkg::t_flpw_sts  o_sts,
    output flpw_pkg::t_flpw_out  o_result,
    output logic                 o_res_valid
);

    localparam int STORE_WORDS = TABLE_FRAMES * flpw_pkg::ENTRY_SLOTS;
    localparam int FRAME_W     = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int ADDR_W      = FRAME_W + flpw_pkg::SLOT_W;

    logic [63:0]            r_store [STORE_WORDS];
    logic [63:0]            r_rd_data;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [3:0]             r_root_frame;
    logic [47:0]            r_va;
    logic                   r_need_user;
    logic                   r_need_write;
    logic [1:0]             r_level;
    flpw_pkg::t_flpw_out    r_res;
    logic                   r_res_valid;
    flpw_pkg::t_flpw_out    n_res;

    logic [31:0]            idx_ext;
    logic                   idx_in_store;
    logic                   is_write;
    logic                   canon;
    logic                   root_out;
    logic                   load_end;
    logic [16:0]            va_top;

    logic [39:0]            e_frame;
    logic                   e_frame_out;
    logic [2:0]             walk_fault;
    logic                   walk_end;
    flpw_pkg::t_flpw_out    walk_res;
    flpw_pkg::t_flpw_out    load_res;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [63:0]            wr_data;
    logic [39:0]            rd_frame;
    logic [8:0]             rd_slot;
    logic [ADDR_W-1:0]      rd_addr;

    // accept-time checks
    always_comb begin
        idx_ext      = 32'(i_item.entry_index);
        idx_in_store = idx_ext < 32'(STORE_WORDS);
        is_write     = i_item.opcode == flpw_pkg::OP_WRITE;
        va_top       = i_item.virt_address[63:flpw_pkg::VIRT_BITS-1];
        canon        = (&va_top) || (~|va_top);
        root_out     = 32'(r_root_frame) >= 32'(TABLE_FRAMES);
        load_end     = is_write || !canon || root_out;

        load_res = '0;
        if (!is_write) begin
            if (!canon) begin
                load_res.fault_code = flpw_pkg::FLT_NONCANON;
            end else if (root_out) begin
                load_res.fault_code = flpw_pkg::FLT_OUTSIDE;
            end
        end
    end

    // one level of the walk on the entry just read
    always_comb begin
        e_frame     = r_rd_data[51:12];
        e_frame_out = e_frame >= 40'(TABLE_FRAMES);
        walk_res    = '0;
        walk_fault  = flpw_pkg::FLT_OK;
        if (r_level != flpw_pkg::LAST_LEVEL) begin
            if (!r_rd_data[flpw_pkg::PTE_PRESENT]) begin
                walk_fault = flpw_pkg::FLT_ABSENT;
            end else if (r_rd_data[flpw_pkg::PTE_LARGE]) begin
                walk_fault = flpw_pkg::FLT_LARGE;
            end else if (e_frame_out) begin
                walk_fault = flpw_pkg::FLT_OUTSIDE;
            end
            walk_end = walk_fault != flpw_pkg::FLT_OK;
        end else begin
            walk_end = 1'b1;
            if (!r_rd_data[flpw_pkg::PTE_PRESENT]) begin
                walk_fault = flpw_pkg::FLT_ABSENT;
            end else begin
                walk_res.kernel_page = !r_rd_data[flpw_pkg::PTE_USER];
                if (r_need_user && !r_rd_data[flpw_pkg::PTE_USER]) begin
                    walk_fault = flpw_pkg::FLT_USER;
                end else if (r_need_write && !r_rd_data[flpw_pkg::PTE_WRITABLE]) begin
                    walk_fault = flpw_pkg::FLT_WRITE;
                end else begin
                    walk_res.phys_address = {e_frame, r_va[flpw_pkg::PAGE_SHIFT-1:0]};
                    walk_res.translated   = 1'b1;
                end
            end
        end
        walk_res.fault_code = walk_fault;
    end

    assign n_res = i_cmd.load ? load_res : walk_res;

    // store ports: one write, one registered read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.load && is_write && idx_in_store) begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[ADDR_W-1:0];
            wr_data = i_item.entry_value;
        end
    end

    always_comb begin
        if (i_cmd.load) begin
            rd_frame = 40'(r_root_frame);
            rd_slot  = i_item.virt_address[47:39];
        end else begin
            rd_frame = e_frame;
            case (r_level)
                2'd0:    rd_slot = r_va[38:30];
                2'd1:    rd_slot = r_va[29:21];
                default: rd_slot = r_va[20:12];
            endcase
        end
        rd_addr = {rd_frame[FRAME_W-1:0], rd_slot};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_root_frame <= '0;
            r_level      <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_root_frame <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_level <= '0;
            end else if (i_cmd.walk) begin
                r_level <= r_level + 1'b1;
            end
            r_res_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_va         <= i_item.virt_address[47:0];
            r_need_user  <= i_item.need_user;
            r_need_write <= i_item.need_write;
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_sts.clr_last = r_clr_addr == ADDR_W'(STORE_WORDS - 1);
    assign o_sts.load_end = load_end;
    assign o_sts.walk_end = walk_end;
    assign o_result       = r_res;
    assign o_res_valid    = r_res_valid;

    a_xlate_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.translated |-> r_res.fault_code == flpw_pkg::FLT_OK)
        else $error("translated result carries a fault");

    a_fault_zero_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && (r_res.fault_code != flpw_pkg::FLT_OK) |-> r_res.phys_address == '0)
        else $error("faulting result carries an address");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk && (r_level == flpw_pkg::LAST_LEVEL) |-> i_cmd.finish)
        else $error("walk continued past the last level");

endmodule

`default_nettype wire

// File: hdl/four_level_page_walker.sv
// Top level of the four-level page walker: controller plus datapath.
// Depends on flpw_pkg, flpw_ctrl and flpw_dp.
`default_nettype none

// An item is taken when start is high and busy is low. A table write finishes in
// its accept cycle; a translation then reads one table level after another (up
// to four levels), since each level waits on one registered read of the single
// store read port. Faults found at accept (noncanonical address, root outside
// the store) also finish in the accept cycle. The result appears on o_result with
// o_res_valid high for one cycle, the cycle after the item's last cycle, and the
// next item may be taken in that same cycle. Results cannot be held off: the
// receiver must take each one in its strobe cycle. After reset the store is
// cleared one word a cycle, with busy high; the root register can be written
// during that time.
module four_level_page_walker #(
    parameter int TABLE_FRAMES = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [3:0]           i_cfg_data,
    input  wire                  start,
    output logic                 busy,
    input  flpw_pkg::t_flpw_in   i_item,
    output flpw_pkg::t_flpw_out  o_result,
    output logic                 o_res_valid
);

    flpw_pkg::t_flpw_cmd cmd;
    flpw_pkg::t_flpw_sts sts;

    flpw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    flpw_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result),
        .o_res_valid (o_res_valid)
    );

endmodule

`default_nettype wire

// File: dv/four_level_page_walker_tb.sv
// Self-checking testbench for four_level_page_walker: directed walks, then random traffic.
// Depends on flpw_pkg and the four_level_page_walker RTL; keeps its own page-table shadow.
`timescale 1ns / 100ps

module four_level_page_walker_tb;

    localparam int TABLE_FRAMES = 16;
    localparam int ENTRY_SLOTS  = flpw_pkg::ENTRY_SLOTS;
    localparam int STORE_WORDS  = TABLE_FRAMES * ENTRY_SLOTS;
    localparam int WALK_LAT     = 6;
    localparam int STALL_LIMIT  = 3 * (STORE_WORDS + 64);

    localparam logic [11:0] F_P = 12'(1 << flpw_pkg::PTE_PRESENT);
    localparam logic [11:0] F_W = 12'(1 << flpw_pkg::PTE_WRITABLE);
    localparam logic [11:0] F_U = 12'(1 << flpw_pkg::PTE_USER);
    localparam logic [11:0] F_L = 12'(1 << flpw_pkg::PTE_LARGE);

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [3:0]          i_cfg_data = 4'd0;
    logic                start      = 1'b0;
    logic                busy;
    flpw_pkg::t_flpw_in  i_item     = '0;
    flpw_pkg::t_flpw_out o_result;
    logic                o_res_valid;

    logic [63:0]         shadow_pt [STORE_WORDS];
    logic [3:0]          shadow_root;
    flpw_pkg::t_flpw_out pending_walks[$];
    int                  n_errors      = 0;
    int                  send_idle_pct = 0;
    int                  stall_cycles  = 0;

    four_level_page_walker #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_res_valid(o_res_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block: applies a store write or predicts one translation.
    function automatic flpw_pkg::t_flpw_out model_walk(input flpw_pkg::t_flpw_in it);
        flpw_pkg::t_flpw_out r;
        logic [16:0]         top;
        logic [39:0]         frame;
        logic [8:0]          slot;
        logic [63:0]         ent;
        int                  idx;
        r = '0;
        if (it.opcode == flpw_pkg::OP_WRITE) begin
            if (int'(it.entry_index) < STORE_WORDS)
                shadow_pt[it.entry_index] = it.entry_value;
            return r;
        end
        top = it.virt_address[63:flpw_pkg::VIRT_BITS-1];
        if (top != '0 && top != '1) begin
            r.fault_code = flpw_pkg::FLT_NONCANON;
            return r;
        end
        frame = 40'(shadow_root);
        if (frame >= TABLE_FRAMES) begin
            r.fault_code = flpw_pkg::FLT_OUTSIDE;
            return r;
        end
        ent = '0;
        for (int lvl = 0; lvl < 4; lvl++) begin
            slot = it.virt_address[39 - flpw_pkg::SLOT_W * lvl +: flpw_pkg::SLOT_W];
            idx  = int'(frame) * ENTRY_SLOTS + int'(slot);
            ent  = shadow_pt[idx];
            if (!ent[flpw_pkg::PTE_PRESENT]) begin
                r.fault_code = flpw_pkg::FLT_ABSENT;
                return r;
            end
            if (lvl < 3) begin
                if (ent[flpw_pkg::PTE_LARGE]) begin
                    r.fault_code = flpw_pkg::FLT_LARGE;
                    return r;
                end
                frame = ent[51:flpw_pkg::PAGE_SHIFT];
                if (frame >= TABLE_FRAMES) begin
                    r.fault_code = flpw_pkg::FLT_OUTSIDE;
                    return r;
                end
            end
        end
        // leaf: large bit ignored, only its own user/writable bits count
        r.kernel_page = !ent[flpw_pkg::PTE_USER];
        if (it.need_user && !ent[flpw_pkg::PTE_USER])
            r.fault_code = flpw_pkg::FLT_USER;
        else if (it.need_write && !ent[flpw_pkg::PTE_WRITABLE])
            r.fault_code = flpw_pkg::FLT_WRITE;
        else begin
            r.phys_address = {ent[51:flpw_pkg::PAGE_SHIFT],
                              it.virt_address[flpw_pkg::PAGE_SHIFT-1:0]};
            r.translated   = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [63:0] pte(input logic [39:0] frame, input logic [11:0] flags);
        return {12'h000, frame, flags};
    endfunction

    function automatic logic [63:0] va_of(input logic [8:0] s0, s1, s2, s3,
                                          input logic [11:0] off);
        return {{16{s0[8]}}, s0, s1, s2, s3, off};
    endfunction

    function automatic flpw_pkg::t_flpw_in store_item(input int index,
                                                      input logic [63:0] value);
        flpw_pkg::t_flpw_in it;
        it             = '0;
        it.opcode      = flpw_pkg::OP_WRITE;
        it.entry_index = 13'(index);
        it.entry_value = value;
        return it;
    endfunction

    function automatic flpw_pkg::t_flpw_in xlate_item(input logic [63:0] va,
                                                      input logic usr, wr);
        flpw_pkg::t_flpw_in it;
        it              = '0;
        it.opcode       = flpw_pkg::OP_XLATE;
        it.virt_address = va;
        it.need_user    = usr;
        it.need_write   = wr;
        return it;
    endfunction

    // Slots drawn mostly from a small set so random writes land on the random walks.
    function automatic logic [8:0] hot_slot();
        case ($urandom_range(4))
            0:       return 9'd0;
            1:       return 9'd511;
            2:       return 9'h155;
            3:       return 9'h0AA;
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    function automatic logic [63:0] random_pte();
        logic [63:0] ent;
        ent = {$urandom, $urandom};
        case ($urandom_range(9))
            0: ent[flpw_pkg::PTE_PRESENT] = 1'b0;
            1: ent[flpw_pkg::PTE_PRESENT] = 1'b1;       // wide frame, good as a leaf
            2: begin
                ent[flpw_pkg::PTE_PRESENT] = 1'b1;
                ent[flpw_pkg::PTE_LARGE]   = 1'b1;
            end
            default: begin
                ent[flpw_pkg::PTE_PRESENT]   = 1'b1;
                ent[flpw_pkg::PTE_LARGE]     = 1'b0;
                ent[51:flpw_pkg::PAGE_SHIFT] = 40'($urandom_range(TABLE_FRAMES - 1));
            end
        endcase
        return ent;
    endfunction

    function automatic flpw_pkg::t_flpw_in random_item();
        flpw_pkg::t_flpw_in it;
        int                 sel;
        sel             = $urandom_range(99);
        it.opcode       = flpw_pkg::OP_XLATE;
        it.entry_index  = 13'($urandom);
        it.entry_value  = {$urandom, $urandom};
        it.virt_address = {$urandom, $urandom};
        it.need_user    = 1'($urandom);
        it.need_write   = 1'($urandom);
        if (sel < 40) begin
            it.opcode      = flpw_pkg::OP_WRITE;
            it.entry_index = 13'($urandom_range(TABLE_FRAMES - 1) * ENTRY_SLOTS + hot_slot());
            it.entry_value = random_pte();
        end else if (sel < 45) begin
            it.opcode = flpw_pkg::OP_WRITE;
        end else if (sel < 93) begin
            it.virt_address = va_of(hot_slot(), hot_slot(), hot_slot(), hot_slot(),
                                    12'($urandom));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        n_errors++;
    endtask

    // One transaction: idle a cycle at a time at the set rate, then hold start
    // until accepted.
    task automatic send_item(input flpw_pkg::t_flpw_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= item;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_walks.push_back(model_walk(item));
    endtask

    task automatic drain_walks();
        start <= 1'b0;
        while (pending_walks.size() != 0) @(posedge i_clk);
        repeat (WALK_LAT) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [3:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_root  = val;
    endtask

    task automatic test_cleared_store();
        send_item(xlate_item(va_of(9'd0, 9'd0, 9'd0, 9'd0, 12'h000), 1'b0, 1'b0));
        send_item(xlate_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
    endtask

    task automatic test_noncanonical();
        send_item(xlate_item(64'h0000_8000_0000_0000, 1'b0, 1'b0));
        send_item(xlate_item(64'hFFFF_7FFF_FFFF_FFFF, 1'b1, 1'b0));
        send_item(xlate_item(64'h8000_0000_0000_0000, 1'b0, 1'b1));
    endtask

    // Chain root(0)/1 -> 5/2 -> 9/3 -> 15/4 -> leaf; upper entries carry no permissions.
    task automatic test_walk_faults();
        logic [63:0] va;
        va = va_of(9'd1, 9'd2, 9'd3, 9'd4, 12'hABC);
        send_item(store_item(0 * ENTRY_SLOTS + 1, pte(40'd5, F_P)));
        send_item(store_item(5 * ENTRY_SLOTS + 2, pte(40'd9, F_P)));
        send_item(store_item(9 * ENTRY_SLOTS + 3, pte(40'd15, F_P)));
        send_item(store_item(15 * ENTRY_SLOTS + 4, pte(40'hFF_FFFF_FFFF, F_P | F_W | F_U)));
        send_item(xlate_item(va, 1'b1, 1'b1));
        send_item(xlate_item(va_of(9'd1, 9'd2, 9'd3, 9'd5, 12'hFFF), 1'b0, 1'b0));
        send_item(xlate_item(va_of(9'd1, 9'd2, 9'd4, 9'd4, 12'h000), 1'b0, 1'b0));
        send_item(store_item(9 * ENTRY_SLOTS + 3, pte(40'd15, F_P | F_L)));
        send_item(xlate_item(va, 1'b0, 1'b0));
        send_item(store_item(9 * ENTRY_SLOTS + 3, pte(40'd16, F_P)));
        send_item(xlate_item(va, 1'b0, 1'b0));
        send_item(store_item(9 * ENTRY_SLOTS + 3, pte(40'd15, F_P)));
    endtask

    task automatic test_leaf_permissions();
        logic [63:0] va;
        va = va_of(9'd1, 9'd2, 9'd3, 9'd4, 12'h5A5);
        send_item(store_item(15 * ENTRY_SLOTS + 4, pte(40'h12_3456_789A, F_P)));
        send_item(xlate_item(va, 1'b1, 1'b0));
        send_item(xlate_item(va, 1'b0, 1'b1));
        send_item(xlate_item(va, 1'b0, 1'b0));
        send_item(store_item(15 * ENTRY_SLOTS + 4, pte(40'hA5_A5A5_A5A5, F_P | F_U)));
        send_item(xlate_item(va, 1'b1, 1'b1));
        // large bit on the leaf is not examined
        send_item(store_item(15 * ENTRY_SLOTS + 4, pte(40'h5A_5A5A_5A5A, F_P | F_U | F_W | F_L)));
        send_item(xlate_item(va, 1'b1, 1'b1));
    endtask

    task automatic test_root_extremes();
        logic [63:0] va;
        va = va_of(9'd1, 9'd2, 9'd3, 9'd4, 12'h001);
        drain_walks();
        write_root(4'd15);
        send_item(xlate_item(va, 1'b0, 1'b0));
        send_item(store_item(15 * ENTRY_SLOTS + 1, pte(40'd5, F_P)));
        send_item(xlate_item(va, 1'b1, 1'b1));
        drain_walks();
        write_root(4'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input logic [3:0] root);
        drain_walks();
        write_root(root);
        send_idle_pct = idle_pct;
        repeat (n_items) send_item(random_item());
    endtask

    // Results cannot be held off: every strobe is a transaction.
    always @(posedge i_clk) begin : check_results
        flpw_pkg::t_flpw_out want;
        if (i_rst_n && o_res_valid) begin
            if (pending_walks.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: %h", o_result));
            end else begin
                want = pending_walks.pop_front();
                if (o_result.phys_address !== want.phys_address)
                    report_mismatch($sformatf("phys_address %h, expected %h",
                                              o_result.phys_address, want.phys_address));
                if (o_result.translated !== want.translated)
                    report_mismatch($sformatf("translated %b, expected %b",
                                              o_result.translated, want.translated));
                if (o_result.fault_code !== want.fault_code)
                    report_mismatch($sformatf("fault_code %0d, expected %0d",
                                              o_result.fault_code, want.fault_code));
                if (o_result.kernel_page !== want.kernel_page)
                    report_mismatch($sformatf("kernel_page %b, expected %b",
                                              o_result.kernel_page, want.kernel_page));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("four_level_page_walker_tb: done, errors");
            $finish;
        end
    end

    initial begin
        foreach (shadow_pt[i]) shadow_pt[i] = '0;
        shadow_root = 4'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_root(4'd0);

        send_idle_pct = 27;
        test_cleared_store();
        test_noncanonical();
        test_walk_faults();
        test_leaf_permissions();
        test_root_extremes();

        test_random_traffic(233, 27, 4'd0);
        test_random_traffic(233, 27, 4'd15);
        test_random_traffic(233, 78, 4'($urandom));
        test_random_traffic(233, 78, 4'd15);
        test_random_traffic(234, 0, 4'd0);
        test_random_traffic(234, 0, 4'($urandom));
        drain_walks();

        if (n_errors == 0)
            $display("four_level_page_walker_tb: done, clean");
        else
            $display("four_level_page_walker_tb: done, errors");
        $finish;
    end

endmodule
